// File: src/pfpr_pkg.sv
// ----------------------------------------------------------------------------
// Phase fault protection relay package
// Shared types and constants for the relay datapath and controller.
// ----------------------------------------------------------------------------
package pfpr_pkg;

  // Field widths.
  localparam int unsigned FuncW   = 3;
  localparam int unsigned MeasW   = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StateW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned NumPh   = 3;

  // Configuration reset values.
  localparam logic [ModeW-1:0] PhaseModeRst   = 2'd2;
  localparam logic [MeasW-1:0] VoltMinRst     = 16'd1980;
  localparam logic [MeasW-1:0] VoltMaxRst     = 16'd2420;
  localparam logic [MeasW-1:0] ThdMaxRst      = 16'd800;
  localparam logic [TimeW-1:0] ReconnectMsRst = 32'd5000;

  // Protection state; the code is also the reported grid state.
  typedef enum logic [StateW-1:0] {
    ST_NORMAL = 2'd0,
    ST_FAULT  = 2'd1,
    ST_WAIT   = 2'd2
  } state_e;

  // Request function codes.
  typedef enum logic [FuncW-1:0] {
    FN_EVAL       = 3'd0,
    FN_FORCE_DISC = 3'd1,
    FN_FORCE_CONN = 3'd2,
    FN_AUTO       = 3'd3,
    FN_INIT       = 3'd4
  } func_e;

  // Phase monitoring modes.
  typedef enum logic [ModeW-1:0] {
    PM_ONE = 2'd0,
    PM_TWO = 2'd1,
    PM_ALL = 2'd2
  } phase_mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHASE_MODE   = 3'd0,
    CFG_VOLT_MIN     = 3'd1,
    CFG_VOLT_MAX     = 3'd2,
    CFG_THD_MAX      = 3'd3,
    CFG_RECONNECT_MS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ModeW-1:0] phase_mode;
    logic [MeasW-1:0] volt_min;
    logic [MeasW-1:0] volt_max;
    logic [MeasW-1:0] thd_max;
    logic [TimeW-1:0] reconnect_ms;
  } cfg_t;

  // One result item.
  typedef struct packed {
    state_e grid_state;
    logic   pulse_connect;
    logic   pulse_disconnect;
    logic   manual_active;
  } res_t;

endpackage

// File: src/phase_fault_protection_relay.sv
// Output: a result appears on the output register in the cycle after its request is accepted.
// Throughput: one request per cycle while no held result stalls; the state
// update of the controller closes through its state registers, and the output
// register takes a new request in the same cycle that its held result is taken.
// Reset: state normal, automatic mode, wait timestamp zero, configuration at
// its defaults, output register empty.
// ----------------------------------------------------------------------------
// Phase fault protection relay
// Three phase lanes check voltage and distortion, the controller merges their
// flags and steps the protection state machine; results go out registered.
// ----------------------------------------------------------------------------
module phase_fault_protection_relay (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfpr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pfpr_pkg::CfgDatW-1:0]  cfg_data_i,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfpr_pkg::FuncW-1:0]    func_i,
  input  logic [pfpr_pkg::MeasW-1:0]    volt_a_i,
  input  logic [pfpr_pkg::MeasW-1:0]    thd_a_i,
  input  logic [pfpr_pkg::MeasW-1:0]    volt_b_i,
  input  logic [pfpr_pkg::MeasW-1:0]    thd_b_i,
  input  logic [pfpr_pkg::MeasW-1:0]    volt_c_i,
  input  logic [pfpr_pkg::MeasW-1:0]    thd_c_i,
  input  logic [pfpr_pkg::TimeW-1:0]    now_ms_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pfpr_pkg::StateW-1:0]   grid_state_o,
  output logic                          pulse_connect_o,
  output logic                          pulse_disconnect_o,
  output logic                          manual_active_o
);
  import pfpr_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [NumPh-1:0]  lane_fault;
  res_t              res, res_q;
  logic              out_valid_q, out_valid_d;
  logic              accept;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PHASE_MODE:   cfg_d.phase_mode   = cfg_data_i[ModeW-1:0];
        CFG_VOLT_MIN:     cfg_d.volt_min     = cfg_data_i[MeasW-1:0];
        CFG_VOLT_MAX:     cfg_d.volt_max     = cfg_data_i[MeasW-1:0];
        CFG_THD_MAX:      cfg_d.thd_max      = cfg_data_i[MeasW-1:0];
        CFG_RECONNECT_MS: cfg_d.reconnect_ms = cfg_data_i[TimeW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_mode   <= PhaseModeRst;
      cfg_q.volt_min     <= VoltMinRst;
      cfg_q.volt_max     <= VoltMaxRst;
      cfg_q.thd_max      <= ThdMaxRst;
      cfg_q.reconnect_ms <= ReconnectMsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Phase lanes.
  pfpr_lane u_lane_a (
    .volt_i (volt_a_i),
    .thd_i  (thd_a_i),
    .cfg_i  (cfg_q),
    .fault_o(lane_fault[0])
  );

  pfpr_lane u_lane_b (
    .volt_i (volt_b_i),
    .thd_i  (thd_b_i),
    .cfg_i  (cfg_q),
    .fault_o(lane_fault[1])
  );

  pfpr_lane u_lane_c (
    .volt_i (volt_c_i),
    .thd_i  (thd_c_i),
    .cfg_i  (cfg_q),
    .fault_o(lane_fault[2])
  );

  // Merge and state machine.
  pfpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .lane_fault_i(lane_fault),
    .now_ms_i    (now_ms_i),
    .cfg_i       (cfg_q),
    .res_o       (res)
  );

  // Output register: accept whenever it is empty or being drained.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign grid_state_o       = res_q.grid_state;
  assign pulse_connect_o    = res_q.pulse_connect;
  assign pulse_disconnect_o = res_q.pulse_disconnect;
  assign manual_active_o    = res_q.manual_active;

  // Checks.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result lost or changed");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept && (!out_valid_q || out_ready_i) |=> !out_valid_q)
    else $error("result without a request");

endmodule

// File: src/pfpr_lane.sv
// ----------------------------------------------------------------------------
// Phase check lane
// Flags one phase as faulty when its voltage leaves the window or its
// distortion exceeds the limit.
// ----------------------------------------------------------------------------
module pfpr_lane (
  input  logic [pfpr_pkg::MeasW-1:0] volt_i,
  input  logic [pfpr_pkg::MeasW-1:0] thd_i,
  input  pfpr_pkg::cfg_t             cfg_i,
  output logic                       fault_o
);
  import pfpr_pkg::*;

  // Window and distortion compares.
  assign fault_o = (volt_i < cfg_i.volt_min) || (volt_i > cfg_i.volt_max) ||
                   (thd_i > cfg_i.thd_max);

endmodule

// File: src/pfpr_ctrl.sv
// ----------------------------------------------------------------------------
// Protection controller
// Merges the lane fault flags by phase mode and runs the normal, fault and
// wait state machine with manual override and timed reconnection.
// ----------------------------------------------------------------------------
module pfpr_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [pfpr_pkg::FuncW-1:0]      func_i,
  input  logic [pfpr_pkg::NumPh-1:0]      lane_fault_i,
  input  logic [pfpr_pkg::TimeW-1:0]      now_ms_i,
  input  pfpr_pkg::cfg_t                  cfg_i,
  output pfpr_pkg::res_t                  res_o
);
  import pfpr_pkg::*;

  state_e             state_q, state_d;
  logic               manual_q, manual_d;
  logic [TimeW-1:0]   wait_start_q, wait_start_d;
  logic               fault;
  logic               timer_done;
  logic [TimeW-1:0]   elapsed;
  func_e              func;
  logic               pulse_conn, pulse_disc;

  assign func = func_e'(func_i);

  // Merge the lane flags according to the phase mode.
  always_comb begin
    case (phase_mode_e'(cfg_i.phase_mode))
      PM_ONE:  fault = lane_fault_i[0];
      PM_TWO:  fault = lane_fault_i[0] | lane_fault_i[1];
      default: fault = |lane_fault_i;
    endcase
  end

  // Wrap-around elapsed time since the fault cleared.
  assign elapsed    = now_ms_i - wait_start_q;
  assign timer_done = (elapsed >= cfg_i.reconnect_ms);

  // Next state.
  always_comb begin
    state_d      = state_q;
    manual_d     = manual_q;
    wait_start_d = wait_start_q;
    unique case (func)
      FN_EVAL: begin
        if (!manual_q) begin
          unique case (state_q)
            ST_NORMAL: begin
              if (fault) state_d = ST_FAULT;
            end
            ST_FAULT: begin
              if (!fault) begin
                state_d      = ST_WAIT;
                wait_start_d = now_ms_i;
              end
            end
            ST_WAIT: begin
              if (fault) begin
                state_d = ST_FAULT;
              end else if (timer_done) begin
                state_d = ST_NORMAL;
              end
            end
            default: state_d = state_q;
          endcase
        end
      end
      FN_FORCE_DISC: begin
        manual_d = 1'b1;
        state_d  = ST_FAULT;
      end
      FN_FORCE_CONN: begin
        manual_d = 1'b1;
        state_d  = ST_NORMAL;
      end
      FN_AUTO: manual_d = 1'b0;
      FN_INIT: state_d = ST_NORMAL;
      default: state_d = state_q;
    endcase
  end

  // Relay pulses.
  always_comb begin
    pulse_conn = 1'b0;
    pulse_disc = 1'b0;
    unique case (func)
      FN_EVAL: begin
        if (!manual_q) begin
          pulse_disc = (state_q == ST_NORMAL) && fault;
          pulse_conn = (state_q == ST_WAIT) && !fault && timer_done;
        end
      end
      FN_FORCE_DISC: pulse_disc = 1'b1;
      FN_FORCE_CONN: pulse_conn = 1'b1;
      FN_INIT:       pulse_conn = 1'b1;
      default: begin
        pulse_conn = 1'b0;
        pulse_disc = 1'b0;
      end
    endcase
  end

  assign res_o.grid_state       = state_d;
  assign res_o.pulse_connect    = pulse_conn;
  assign res_o.pulse_disconnect = pulse_disc;
  assign res_o.manual_active    = manual_d;

  // State registers advance only on an accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_NORMAL;
      manual_q     <= 1'b0;
      wait_start_q <= '0;
    end else if (accept_i) begin
      state_q      <= state_d;
      manual_q     <= manual_d;
      wait_start_q <= wait_start_d;
    end
  end

  // Checks.
  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.pulse_connect && res_o.pulse_disconnect))
    else $error("connect and disconnect pulses together");

  a_disc_to_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.pulse_disconnect |=> state_q == ST_FAULT)
    else $error("disconnect pulse without entering fault");

  a_conn_to_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.pulse_connect |=> state_q == ST_NORMAL)
    else $error("connect pulse without entering normal");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(state_q) && $stable(manual_q) && $stable(wait_start_q))
    else $error("state changed without a request");

  a_manual_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && manual_q && func == FN_EVAL |=> $stable(state_q))
    else $error("evaluation changed state in manual mode");

endmodule
